@@ rtl/rspg_pkg.sv @@
// ----------------------------------------------------------------------------
// rspg_pkg
// Shared types and constants of the raster scan position generator.
// ----------------------------------------------------------------------------
package rspg_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [31:0]            frame_type;
   typedef logic [11:0]            index_type;
   typedef logic signed [15:0]     angle_type;
   typedef logic signed [15:0]     drive_type;

   // register map
   localparam csr_index_type REG_PIXEL_COUNT     = 3'd0;
   localparam csr_index_type REG_LINE_COUNT      = 3'd1;
   localparam csr_index_type REG_BIDIRECTIONAL   = 3'd2;
   localparam csr_index_type REG_AZIMUTH_START   = 3'd3;
   localparam csr_index_type REG_AZIMUTH_END     = 3'd4;
   localparam csr_index_type REG_ELEVATION_START = 3'd5;
   localparam csr_index_type REG_ELEVATION_END   = 3'd6;

   localparam logic [12:0] COUNT_RESET = 13'd256;
   localparam drive_type   Q14_ONE     = 16'sd16384;

endpackage

@@ rtl/raster_scan_position_generator.sv @@
// ----------------------------------------------------------------------------
// raster_scan_position_generator
// Maps a frame number to a raster position, drive commands and angles.
// ----------------------------------------------------------------------------
//  channel   ports                               transfer when
//  request   start, busy, req_frame_number       start high and busy low
//  response  rsp_strobe, rsp_*                   rsp_strobe high (one cycle)
//  config    csr_write_enable, csr_index, csr_*  csr_write_enable high
//
// One frame number enters every cycle; busy is always low. The pipeline
// holds the two 32-stage dividers for column and line and the
// (COUNT_WIDTH+18)-stage rounding dividers for drives and angles. Reset
// loads the register defaults and empties the pipeline. The receiver
// cannot stall, so nothing ever waits.
// ----------------------------------------------------------------------------
module raster_scan_position_generator #(
   parameter int COUNT_WIDTH = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rspg_pkg::frame_type    req_frame_number,
   output logic                   rsp_strobe,
   output rspg_pkg::index_type    rsp_column,
   output rspg_pkg::index_type    rsp_line,
   output rspg_pkg::frame_type    rsp_sample_index,
   output rspg_pkg::drive_type    rsp_x_drive,
   output rspg_pkg::drive_type    rsp_y_drive,
   output rspg_pkg::angle_type    rsp_azimuth,
   output rspg_pkg::angle_type    rsp_elevation,
   output logic                   rsp_reversed,
   output logic                   rsp_angle_valid,
   input  logic                   csr_write_enable,
   input  rspg_pkg::csr_index_type csr_index,
   input  rspg_pkg::csr_data_type  csr_write_data
);
   import rspg_pkg::*;

   localparam int CNT_W  = COUNT_WIDTH + 1;
   localparam int IDX_W  = COUNT_WIDTH;
   localparam int NUM_W  = COUNT_WIDTH + 18;
   localparam int PROD_W = COUNT_WIDTH + 18;
   localparam int MAG_W  = COUNT_WIDTH + 16;

   // configuration registers
   logic [12:0] pixel_count_ff, line_count_ff;
   logic        bidirectional_ff;
   angle_type   azimuth_start_ff, azimuth_end_ff;
   angle_type   elevation_start_ff, elevation_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff     <= COUNT_RESET;
         line_count_ff      <= COUNT_RESET;
         bidirectional_ff   <= 1'b0;
         azimuth_start_ff   <= '0;
         azimuth_end_ff     <= '0;
         elevation_start_ff <= '0;
         elevation_end_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_PIXEL_COUNT:     pixel_count_ff     <= csr_write_data[12:0];
            REG_LINE_COUNT:      line_count_ff      <= csr_write_data[12:0];
            REG_BIDIRECTIONAL:   bidirectional_ff   <= csr_write_data[0];
            REG_AZIMUTH_START:   azimuth_start_ff   <= csr_write_data;
            REG_AZIMUTH_END:     azimuth_end_ff     <= csr_write_data;
            REG_ELEVATION_START: elevation_start_ff <= csr_write_data;
            REG_ELEVATION_END:   elevation_end_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Clamp counts: zero acts as one, anything above 2^COUNT_WIDTH is capped.
   // The user must change registers only while the pipeline is empty; the block
   // itself does not enforce this. All stages read them directly.
   logic [31:0]      pc32, lc32, cmax32;
   logic [CNT_W-1:0] n_cnt, m_cnt, x_den, y_den;
   logic             x_ok, y_ok;

   always_comb begin
      pc32   = 32'(pixel_count_ff);
      lc32   = 32'(line_count_ff);
      cmax32 = 32'd1 << COUNT_WIDTH;
      if (pc32 == 32'd0) begin
         n_cnt = CNT_W'(1);
      end else if (pc32 > cmax32) begin
         n_cnt = CNT_W'(cmax32);
      end else begin
         n_cnt = CNT_W'(pc32);
      end
      if (lc32 == 32'd0) begin
         m_cnt = CNT_W'(1);
      end else if (lc32 > cmax32) begin
         m_cnt = CNT_W'(cmax32);
      end else begin
         m_cnt = CNT_W'(lc32);
      end
      x_ok  = n_cnt >= CNT_W'(2);
      y_ok  = m_cnt >= CNT_W'(2);
      x_den = n_cnt - CNT_W'(1);
      y_den = m_cnt - CNT_W'(1);
   end

   assign busy = 1'b0;

   // Stage A: make the frame number zero based.
   logic      a_vld_ff;
   frame_type a_zb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start & ~busy;
      end
      a_zb_ff <= (req_frame_number == '0) ? '0 : req_frame_number - 32'd1;
   end

   // Column step and line quotient.
   logic             d1_vld;
   frame_type        d1_quot, d1_zb;
   logic [CNT_W-1:0] d1_rem;

   rspg_div #(.NUM_W(32), .DEN_W(CNT_W), .SIDE_W(32)) u_div_col (
      .clock(clock), .reset(reset),
      .in_valid(a_vld_ff), .in_num(a_zb_ff), .in_den(n_cnt), .in_side(a_zb_ff),
      .out_valid(d1_vld), .out_quot(d1_quot), .out_rem(d1_rem), .out_side(d1_zb)
   );

   // Line index wraps at the line count.
   logic             d2_vld;
   logic [31:0]      d2_quot;
   logic [CNT_W-1:0] d2_rem;
   logic [32+IDX_W-1:0] d2_side;

   rspg_div #(.NUM_W(32), .DEN_W(CNT_W), .SIDE_W(32 + IDX_W)) u_div_line (
      .clock(clock), .reset(reset),
      .in_valid(d1_vld), .in_num(d1_quot), .in_den(m_cnt),
      .in_side({d1_zb, d1_rem[IDX_W-1:0]}),
      .out_valid(d2_vld), .out_quot(d2_quot), .out_rem(d2_rem), .out_side(d2_side)
   );

   // Stage B: reverse odd lines when bidirectional, form the angle products.
   logic              b_rev_in;
   logic [CNT_W-1:0]  b_x_in;
   logic signed [16:0] az_diff, el_diff;

   assign b_rev_in = bidirectional_ff & d2_rem[0];
   assign b_x_in   = b_rev_in ? n_cnt - CNT_W'(1) - {1'b0, d2_side[IDX_W-1:0]}
                              : {1'b0, d2_side[IDX_W-1:0]};
   assign az_diff  = 17'(azimuth_end_ff) - 17'(azimuth_start_ff);
   assign el_diff  = 17'(elevation_start_ff) - 17'(elevation_end_ff);

   logic                     b_vld_ff, b_rev_ff;
   frame_type                b_zb_ff;
   logic [IDX_W-1:0]         b_x_ff, b_y_ff;
   logic signed [PROD_W-1:0] b_az_prod_ff, b_el_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= d2_vld;
      end
      b_rev_ff     <= b_rev_in;
      b_zb_ff      <= d2_side[32+IDX_W-1:IDX_W];
      b_x_ff       <= b_x_in[IDX_W-1:0];
      b_y_ff       <= d2_rem[IDX_W-1:0];
      b_az_prod_ff <= PROD_W'(az_diff * $signed({1'b0, b_x_in[IDX_W-1:0]}));
      b_el_prod_ff <= PROD_W'(el_diff * $signed({1'b0, d2_rem[IDX_W-1:0]}));
   end

   // Stage C: rounding numerators, 2*num + den over 2*den.
   logic [PROD_W-1:0] az_abs, el_abs;
   assign az_abs = b_az_prod_ff[PROD_W-1] ? PROD_W'(-b_az_prod_ff) : b_az_prod_ff;
   assign el_abs = b_el_prod_ff[PROD_W-1] ? PROD_W'(-b_el_prod_ff) : b_el_prod_ff;

   logic             c_vld_ff, c_rev_ff, c_az_neg_ff, c_el_neg_ff;
   frame_type        c_zb_ff;
   logic [IDX_W-1:0] c_x_ff, c_y_ff;
   logic [NUM_W-1:0] c_xnum_ff, c_ynum_ff, c_anum_ff, c_enum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
      c_rev_ff    <= b_rev_ff;
      c_zb_ff     <= b_zb_ff;
      c_x_ff      <= b_x_ff;
      c_y_ff      <= b_y_ff;
      c_az_neg_ff <= b_az_prod_ff[PROD_W-1];
      c_el_neg_ff <= b_el_prod_ff[PROD_W-1];
      c_xnum_ff   <= (NUM_W'(b_x_ff) << 16) + NUM_W'(x_den);
      c_ynum_ff   <= (NUM_W'(b_y_ff) << 16) + NUM_W'(y_den);
      c_anum_ff   <= {az_abs[MAG_W-1:0], 1'b0} + NUM_W'(x_den);
      c_enum_ff   <= {el_abs[MAG_W-1:0], 1'b0} + NUM_W'(y_den);
   end

   logic [CNT_W-1:0] x_den2, y_den2;
   assign x_den2 = {x_den[CNT_W-2:0], 1'b0};
   assign y_den2 = {y_den[CNT_W-2:0], 1'b0};

   // Four rounding dividers run side by side; one carries the sideband.
   localparam int SB_W = 32 + 2 * IDX_W + 3;

   logic             e_vld;
   logic [SB_W-1:0]  e_side;
   logic [NUM_W-1:0] qx, qy, qa, qe;

   rspg_div #(.NUM_W(NUM_W), .DEN_W(CNT_W), .SIDE_W(SB_W)) u_div_x (
      .clock(clock), .reset(reset),
      .in_valid(c_vld_ff), .in_num(c_xnum_ff), .in_den(x_den2),
      .in_side({c_zb_ff, c_x_ff, c_y_ff, c_rev_ff, c_az_neg_ff, c_el_neg_ff}),
      .out_valid(e_vld), .out_quot(qx), .out_rem(), .out_side(e_side)
   );
   rspg_div #(.NUM_W(NUM_W), .DEN_W(CNT_W), .SIDE_W(1)) u_div_y (
      .clock(clock), .reset(reset),
      .in_valid(c_vld_ff), .in_num(c_ynum_ff), .in_den(y_den2), .in_side(1'b0),
      .out_valid(), .out_quot(qy), .out_rem(), .out_side()
   );
   rspg_div #(.NUM_W(NUM_W), .DEN_W(CNT_W), .SIDE_W(1)) u_div_az (
      .clock(clock), .reset(reset),
      .in_valid(c_vld_ff), .in_num(c_anum_ff), .in_den(x_den2), .in_side(1'b0),
      .out_valid(), .out_quot(qa), .out_rem(), .out_side()
   );
   rspg_div #(.NUM_W(NUM_W), .DEN_W(CNT_W), .SIDE_W(1)) u_div_el (
      .clock(clock), .reset(reset),
      .in_valid(c_vld_ff), .in_num(c_enum_ff), .in_den(y_den2), .in_side(1'b0),
      .out_valid(), .out_quot(qe), .out_rem(), .out_side()
   );

   // Stage F: apply offsets and signs, zero an axis with fewer than two.
   logic      e_az_neg, e_el_neg;
   angle_type az_step, el_step;
   assign e_az_neg = e_side[1];
   assign e_el_neg = e_side[0];
   assign az_step  = e_az_neg ? -16'(qa) : 16'(qa);
   assign el_step  = e_el_neg ? -16'(qe) : 16'(qe);

   logic       f_vld_ff, f_rev_ff, f_valid_ff;
   frame_type  f_zb_ff;
   index_type  f_col_ff, f_line_ff;
   drive_type  f_xd_ff, f_yd_ff;
   angle_type  f_az_ff, f_el_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= e_vld;
      end
      f_zb_ff    <= e_side[SB_W-1:SB_W-32];
      f_col_ff   <= 12'(e_side[2*IDX_W+2:IDX_W+3]);
      f_line_ff  <= 12'(e_side[IDX_W+2:3]);
      f_rev_ff   <= e_side[2];
      f_valid_ff <= x_ok & y_ok;
      f_xd_ff    <= x_ok ? 16'(qx) - Q14_ONE : '0;
      f_yd_ff    <= y_ok ? Q14_ONE - 16'(qy) : '0;
      f_az_ff    <= x_ok ? azimuth_start_ff + az_step : '0;
      f_el_ff    <= y_ok ? elevation_end_ff + el_step : '0;
   end

   assign rsp_strobe       = f_vld_ff;
   assign rsp_column       = f_col_ff;
   assign rsp_line         = f_line_ff;
   assign rsp_sample_index = f_zb_ff;
   assign rsp_x_drive      = f_xd_ff;
   assign rsp_y_drive      = f_yd_ff;
   assign rsp_azimuth      = f_az_ff;
   assign rsp_elevation    = f_el_ff;
   assign rsp_reversed     = f_rev_ff;
   assign rsp_angle_valid  = f_valid_ff;

   logic unused_quot;
   assign unused_quot = ^d2_quot;

endmodule

@@ rtl/rspg_div.sv @@
// ----------------------------------------------------------------------------
// rspg_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module rspg_div #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 13,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [DEN_W-1:0]  out_rem,
   output logic [SIDE_W-1:0] out_side
);

   logic              vld_ff  [NUM_W];
   logic [NUM_W-1:0]  work_ff [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic              vld_i;
      logic [NUM_W-1:0]  work_i;
      logic [DEN_W-1:0]  rem_i;
      logic [DEN_W-1:0]  den_i;
      logic [SIDE_W-1:0] side_i;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  work_in;

      if (s == 0) begin : g_first
         assign vld_i  = in_valid;
         assign work_i = in_num;
         assign rem_i  = '0;
         assign den_i  = in_den;
         assign side_i = in_side;
      end else begin : g_next
         assign vld_i  = vld_ff[s-1];
         assign work_i = work_ff[s-1];
         assign rem_i  = rem_ff[s-1];
         assign den_i  = den_ff[s-1];
         assign side_i = side_ff[s-1];
      end

      // shift in the next numerator bit, subtract when it fits
      assign trial   = {rem_i, work_i[NUM_W-1]};
      assign diff    = trial - {1'b0, den_i};
      assign ge      = trial >= {1'b0, den_i};
      assign rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign work_in = {work_i[NUM_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_i;
         end
         work_ff[s] <= work_in;
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= den_i;
         side_ff[s] <= side_i;
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = work_ff[NUM_W-1];
   assign out_rem   = rem_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives frame numbers into the raster scan position generator under a range
// of register settings and checks every response against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rspg_pkg::*;

   localparam int LATENCY    = 98;
   localparam int WATCHDOG   = 2000;
   localparam int COUNT_MAX  = 4096;

   typedef struct packed {
      index_type column;
      index_type line;
      frame_type sample_index;
      drive_type x_drive;
      drive_type y_drive;
      angle_type azimuth;
      angle_type elevation;
      logic      reversed;
      logic      angle_valid;
   } position_type;

   // Scoreboard: hold the register copy, predict positions, compare responses.
   class position_scoreboard;
      logic [12:0] pixel_count;
      logic [12:0] line_count;
      logic        bidirectional;
      angle_type   az_start, az_end, el_start, el_end;
      position_type pending[$];
      int mismatches;

      function void load_defaults();
         pixel_count = COUNT_RESET;
         line_count = COUNT_RESET;
         bidirectional = 1'b0;
         az_start = '0;
         az_end = '0;
         el_start = '0;
         el_end = '0;
      endfunction

      function void write_reg(csr_index_type idx, csr_data_type data);
         case (idx)
            REG_PIXEL_COUNT:     pixel_count = data[12:0];
            REG_LINE_COUNT:      line_count = data[12:0];
            REG_BIDIRECTIONAL:   bidirectional = data[0];
            REG_AZIMUTH_START:   az_start = data;
            REG_AZIMUTH_END:     az_end = data;
            REG_ELEVATION_START: el_start = data;
            REG_ELEVATION_END:   el_end = data;
            default: ;
         endcase
      endfunction

      // Round to nearest, tie away from zero, then offset from the base end.
      function longint blend(longint base, longint far, longint idx, longint den);
         longint num;
         longint mag;
         longint q;
         num = (far - base) * idx;
         mag = num < 0 ? -num : num;
         q = (2 * mag + den) / (2 * den);
         return base + (num < 0 ? -q : q);
      endfunction

      function longint usable_count(logic [12:0] c);
         if (c == 0) return 1;
         if (c > COUNT_MAX) return COUNT_MAX;
         return c;
      endfunction

      function void note_frame(frame_type frame);
         position_type p;
         longint n, m, zb, step, row, col;
         n = usable_count(pixel_count);
         m = usable_count(line_count);
         zb = frame == 0 ? 0 : longint'(frame) - 1;
         step = zb % n;
         row = (zb / n) % m;
         p.reversed = bidirectional && row[0];
         col = p.reversed ? n - 1 - step : step;
         p.column = col[11:0];
         p.line = row[11:0];
         p.sample_index = zb[31:0];
         p.angle_valid = (n >= 2) && (m >= 2);
         p.x_drive = '0;
         p.azimuth = '0;
         p.y_drive = '0;
         p.elevation = '0;
         if (n >= 2) begin
            p.x_drive = 16'(-16384 + (2 * col * 32768 + n - 1) / (2 * (n - 1)));
            p.azimuth = 16'(blend(az_start, az_end, col, n - 1));
         end
         if (m >= 2) begin
            p.y_drive = 16'(16384 - (2 * row * 32768 + m - 1) / (2 * (m - 1)));
            p.elevation = 16'(blend(el_end, el_start, row, m - 1));
         end
         pending.push_back(p);
      endfunction

      function void check_position(position_type got);
         position_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: column %0d line %0d", got.column, got.line);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   frame_type req_frame_number = '0;
   logic rsp_strobe;
   position_type observed;
   logic csr_write_enable = 1'b0;
   csr_index_type csr_index = '0;
   csr_data_type csr_write_data = '0;

   position_scoreboard board = new();
   int idle_cycles = 0;
   int idle_pct = 28;
   bit timed_out = 1'b0;

   always #1 clock = ~clock;

   raster_scan_position_generator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_frame_number(req_frame_number),
      .rsp_strobe(rsp_strobe),
      .rsp_column(observed.column), .rsp_line(observed.line),
      .rsp_sample_index(observed.sample_index),
      .rsp_x_drive(observed.x_drive), .rsp_y_drive(observed.y_drive),
      .rsp_azimuth(observed.azimuth), .rsp_elevation(observed.elevation),
      .rsp_reversed(observed.reversed), .rsp_angle_valid(observed.angle_valid),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Check each response at the edge that ends its strobe cycle; count idle cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_position(observed);
         if (rsp_strobe || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Write one register; the block must be idle here.
   task automatic write_reg(csr_index_type idx, csr_data_type data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      board.write_reg(idx, data);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Present one frame number and hold start until the transfer happens.
   // Start stays high when the next transfer follows without a gap.
   task automatic send_frame(frame_type frame);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_frame_number <= frame;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_frame(frame);
   endtask

   // Drop start and wait for every response plus the pipeline depth.
   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_geometry(int pixels, int lines, bit bidir,
                               int az0, int az1, int el0, int el1);
      write_reg(REG_PIXEL_COUNT, 16'(pixels));
      write_reg(REG_LINE_COUNT, 16'(lines));
      write_reg(REG_BIDIRECTIONAL, 16'(bidir));
      write_reg(REG_AZIMUTH_START, 16'(az0));
      write_reg(REG_AZIMUTH_END, 16'(az1));
      write_reg(REG_ELEVATION_START, 16'(el0));
      write_reg(REG_ELEVATION_END, 16'(el1));
   endtask

   // Mostly frames within three full scans of the current geometry, plus noise.
   function automatic frame_type pick_frame();
      int span;
      span = int'(board.usable_count(board.pixel_count) *
                  board.usable_count(board.line_count));
      if ($urandom_range(9) < 7) return frame_type'($urandom_range(3 * span));
      return $urandom();
   endfunction

   task automatic random_phase(int items);
      repeat (items) send_frame(pick_frame());
   endtask

   initial begin
      board.load_defaults();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: default geometry, frame number extremes and zero.
      send_frame(32'd0);
      send_frame(32'd1);
      send_frame(32'd2);
      send_frame(32'd256);
      send_frame(32'd257);
      send_frame(32'hFFFF_FFFF);
      send_frame(32'h8000_0000);
      drain();

      // Bidirectional, extreme angles, small frame to reach reversed lines.
      set_geometry(3, 4, 1, -23040, 23040, 23040, -23040);
      for (int f = 1; f <= 9; f++) send_frame(frame_type'(f));
      drain();

      // Counts of zero and one, and counts above the supported range.
      set_geometry(0, 1, 1, 100, -100, 5, 7);
      send_frame(32'd5);
      send_frame(32'd0);
      drain();
      set_geometry(8191, 4097, 1, 23040, -23040, -23040, 23040);
      send_frame(32'd4096);
      send_frame(32'd4097);
      send_frame(32'hFFFF_FFFF);
      drain();

      // Random settings; the middle phase runs without idling.
      for (int phase = 0; phase < 8; phase++) begin
         idle_pct = (phase == 4) ? 0 : 28;
         set_geometry($urandom_range(9) < 2 ? $urandom_range(8191) : $urandom_range(1, 20),
                      $urandom_range(9) < 2 ? $urandom_range(8191) : $urandom_range(1, 20),
                      $urandom_range(1),
                      $urandom_range(46080) - 23040, $urandom_range(46080) - 23040,
                      $urandom_range(46080) - 23040, $urandom_range(46080) - 23040);
         random_phase(52);
         drain();
      end

      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/rspg_pkg.sv
rtl/rspg_div.sv
rtl/raster_scan_position_generator.sv
verif/testbench.sv
